### rtl/utu8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package utu8_pkg;

    localparam int unsigned UnitW  = 16;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned HeldW  = 10;
    localparam int unsigned PointW = 21;
    localparam int unsigned MaxBytes = 4;

    localparam logic [5:0] HighTag = 6'b110110;
    localparam logic [5:0] LowTag  = 6'b110111;

    localparam logic [PointW-1:0] SuppBase = 21'h10000;
    localparam logic [PointW-1:0] Lim1Byte = 21'h80;
    localparam logic [PointW-1:0] Lim2Byte = 21'h800;
    localparam logic [PointW-1:0] Lim3Byte = 21'h10000;

    localparam logic [ByteW-1:0] Lead2 = 8'hc0;
    localparam logic [ByteW-1:0] Lead3 = 8'he0;
    localparam logic [ByteW-1:0] Lead4 = 8'hf0;
    localparam logic [ByteW-1:0] Cont  = 8'h80;

    // One encoded code point: bytes in emission order, count of zero means nothing to send.
    typedef struct packed {
        logic [MaxBytes-1:0][ByteW-1:0] bytes;
        logic [2:0]                     count;
        logic                           str_end;
    } t_enc;

endpackage

### rtl/utu8_encode.sv
// Surrogate pairing and UTF-8 byte formation for one code unit.
module utu8_encode
    import utu8_pkg::*;
(
    input  logic [UnitW-1:0] i_unit,
    input  logic             i_last,
    input  logic             i_pending,
    input  logic [HeldW-1:0] i_held,
    output t_enc             o_enc,
    output logic             o_pending,
    output logic [HeldW-1:0] o_held
);

    logic              is_high;
    logic              is_low;
    logic [PointW-1:0] cp;

    assign is_high = (i_unit[15:10] == HighTag);
    assign is_low  = (i_unit[15:10] == LowTag);

    always_comb begin
        cp        = '0;
        o_enc     = '0;
        o_pending = 1'b0;
        o_held    = '0;
        o_enc.str_end = i_last;
        priority if (i_pending) begin
            // Any follower is consumed; a non-low follower contributes nothing.
            cp = SuppBase + {1'b0, i_held, 10'b0};
            if (is_low) begin
                cp[9:0] = i_unit[9:0];
            end
            o_enc.count = 3'd4;
            o_enc.bytes[0] = Lead4 | {5'b0, cp[20:18]};
            o_enc.bytes[1] = Cont | {2'b0, cp[17:12]};
            o_enc.bytes[2] = Cont | {2'b0, cp[11:6]};
            o_enc.bytes[3] = Cont | {2'b0, cp[5:0]};
        end else if (is_high) begin
            // Held until the next unit; dropped if it ends the string.
            o_pending = !i_last;
            o_held    = i_last ? '0 : i_unit[9:0];
        end else begin
            cp = {5'b0, i_unit};
            priority if (cp < Lim1Byte) begin
                o_enc.count = 3'd1;
                o_enc.bytes[0] = {1'b0, cp[6:0]};
            end else if (cp < Lim2Byte) begin
                o_enc.count = 3'd2;
                o_enc.bytes[0] = Lead2 | {3'b0, cp[10:6]};
                o_enc.bytes[1] = Cont | {2'b0, cp[5:0]};
            end else if (cp < Lim3Byte) begin
                o_enc.count = 3'd3;
                o_enc.bytes[0] = Lead3 | {4'b0, cp[15:12]};
                o_enc.bytes[1] = Cont | {2'b0, cp[11:6]};
                o_enc.bytes[2] = Cont | {2'b0, cp[5:0]};
            end else begin
                o_enc.count = 3'd0;
            end
        end
    end

endmodule

### rtl/utu8_out.sv
// Result register that hands out the bytes of one code point in order.
module utu8_out
    import utu8_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_enc             i_enc,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_run_last,
    output logic             o_string_end
);

    logic                           r_valid;
    logic [MaxBytes-1:0][ByteW-1:0] r_bytes;
    logic [1:0]                     r_idx;
    logic [1:0]                     r_last_idx;
    logic                           r_end;
    logic                           take;

    assign o_valid      = r_valid;
    assign o_out_byte   = r_bytes[r_idx];
    assign o_run_last   = (r_idx == r_last_idx);
    assign o_string_end = o_run_last & r_end;
    assign take         = r_valid & ~i_stall;
    assign o_free       = ~r_valid | (take & o_run_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= ~o_run_last;
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes    <= i_enc.bytes;
            r_last_idx <= 2'(i_enc.count - 3'd1);
            r_end      <= i_enc.str_end;
        end
    end

endmodule

### rtl/utu8_to_dummy_guard.sv
// Input register holding one accepted code unit until the encoder can pass it on.
module utu8_to_dummy_guard
    import utu8_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [UnitW-1:0] i_unit,
    input  logic             i_last,
    input  logic             i_move,
    output logic             o_full,
    output logic             o_stall,
    output logic [UnitW-1:0] o_unit,
    output logic             o_last
);

    logic             r_full;
    logic [UnitW-1:0] r_unit;
    logic             r_last;
    logic             accept;

    assign o_stall = r_full & ~i_move;
    assign accept  = i_valid & ~o_stall;
    assign o_full  = r_full;
    assign o_unit  = r_unit;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= 1'b1;
        end else if (i_move) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_unit <= i_unit;
            r_last <= i_last;
        end
    end

endmodule

### rtl/utf16_to_utf8_transcoder.sv
// A unit accepted into the input register is loaded into the result register once that register
// is free, so its first UTF-8 byte is on the output after the load and can then be taken.
// Throughput: one unit per cycle while each yields one byte and the output is not stalled; a unit
// yielding n bytes holds the result register until its n bytes are taken, setting the rate
// for wider characters. A leading high surrogate produces no byte of its own.
// Reset (synchronous, active low) empties both registers and clears any held surrogate.
module utf16_to_utf8_transcoder
    import utu8_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [UnitW-1:0] i_code_unit,
    input  logic             i_last_unit,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_run_last,
    output logic             o_string_end
);

    // Surrogate pairing state, updated as each unit leaves the input register.
    logic             r_pending;
    logic [HeldW-1:0] r_held;
    logic             n_pending;
    logic [HeldW-1:0] n_held;

    logic             in_full;
    logic [UnitW-1:0] in_unit;
    logic             in_last;
    logic             out_free;
    logic             move;
    logic             load;
    t_enc             enc;

    // The input register holds one item; it stalls the source only when that
    // item cannot leave, so a new item is taken while results are still going out.
    utu8_to_dummy_guard u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_unit  (i_code_unit),
        .i_last  (i_last_unit),
        .i_move  (move),
        .o_full  (in_full),
        .o_stall (o_stall),
        .o_unit  (in_unit),
        .o_last  (in_last)
    );

    utu8_encode u_enc (
        .i_unit    (in_unit),
        .i_last    (in_last),
        .i_pending (r_pending),
        .i_held    (r_held),
        .o_enc     (enc),
        .o_pending (n_pending),
        .o_held    (n_held)
    );

    // An item that yields no byte (a held or dropped high surrogate) leaves at
    // once; otherwise it waits until the result register is empty or finishing.
    assign move = in_full & ((enc.count == 3'd0) | out_free);
    assign load = move & (enc.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= '0;
        end else if (move) begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

    utu8_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_enc        (enc),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule

### test/utf16_to_utf8_transcoder_test.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder, with directed and random strings.
module utf16_to_utf8_transcoder_test;

    import utu8_pkg::*;

    // One UTF-8 byte as the block should emit it, with its two end flags.
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             unit_end;
        logic             text_end;
    } t_utf8_byte;

    // One row of the directed table. Where hand_typed is set, the bytes are given
    // first byte first in lead_first, and count says how many of them are used.
    typedef struct packed {
        logic [UnitW-1:0] unit;
        logic             fin;
        logic             hand_typed;
        logic [2:0]       count;
        logic [31:0]      lead_first;
    } t_stim_row;

    localparam int NumDirected = 24;
    localparam int NumRandom   = 156;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [UnitW-1:0] i_code_unit;
    logic             i_last_unit;
    logic             o_valid;
    logic             i_stall;
    logic [ByteW-1:0] o_out_byte;
    logic             o_run_last;
    logic             o_string_end;

    // The bytes still owed by the block, oldest first.
    t_utf8_byte due_bytes[$];

    // The transcoder's own state as this bench tracks it.
    logic         pair_open;
    logic [9:0]   high_bits;

    int fail_count  = 0;
    int units_sent  = 0;
    int bytes_taken = 0;

    t_stim_row directed_rows [NumDirected];

    utf16_to_utf8_transcoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_code_unit  (i_code_unit),
        .i_last_unit  (i_last_unit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Works out the UTF-8 bytes for one accepted code unit and advances the
    // surrogate state. A unit that only opens a pair, or a high surrogate that
    // closes a string, yields no bytes at all.
    task automatic transcode_unit(input logic [UnitW-1:0] unit, input logic fin,
                                  output logic [3:0][7:0] seq, output int count);
        logic [20:0] point;
        seq   = '0;
        count = 0;
        if (pair_open) begin
            // The follower is always consumed; only a genuine low surrogate adds its bits.
            point = 21'h10000 + {1'b0, high_bits, 10'd0};
            if (unit >= 16'hDC00 && unit < 16'hE000) begin
                point = point + {11'd0, unit[9:0]};
            end
            pair_open = 1'b0;
            high_bits = '0;
        end else if (unit >= 16'hD800 && unit < 16'hDC00) begin
            if (!fin) begin
                pair_open = 1'b1;
                high_bits = unit[9:0];
            end
            return;
        end else begin
            point = {5'd0, unit};
        end

        if (point < 21'h80) begin
            seq[0] = {1'b0, point[6:0]};
            count  = 1;
        end else if (point < 21'h800) begin
            seq[0] = {3'b110, point[10:6]};
            seq[1] = {2'b10, point[5:0]};
            count  = 2;
        end else if (point < 21'h10000) begin
            seq[0] = {4'b1110, point[15:12]};
            seq[1] = {2'b10, point[11:6]};
            seq[2] = {2'b10, point[5:0]};
            count  = 3;
        end else begin
            seq[0] = {5'b11110, point[20:18]};
            seq[1] = {2'b10, point[17:12]};
            seq[2] = {2'b10, point[11:6]};
            seq[3] = {2'b10, point[5:0]};
            count  = 4;
        end
    endtask

    // Offers one item until the block takes it, then books the bytes it owes.
    // The sender never idles inside a fixed window of the random part.
    task automatic offer_unit(input logic [UnitW-1:0] unit, input logic fin,
                              input logic hand_typed = 1'b0, input logic [2:0] typed_count = 3'd0,
                              input logic [31:0] lead_first = 32'd0);
        logic [3:0][7:0] seq;
        int              count;
        t_utf8_byte      b;
        bit              quiet;
        quiet = units_sent >= NumDirected + 60 && units_sent < NumDirected + 100;
        while (!quiet && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= unit;
        i_last_unit <= fin;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        units_sent++;
        transcode_unit(unit, fin, seq, count);
        if (hand_typed) begin
            // The state still advances above; only the bytes come from the table.
            count = typed_count;
            for (int k = 0; k < 4; k++) begin
                seq[k] = lead_first[31-8*k -: 8];
            end
        end
        for (int k = 0; k < count; k++) begin
            b.data     = seq[k];
            b.unit_end = (k == count - 1);
            b.text_end = fin && (k == count - 1);
            due_bytes.push_back(b);
        end
    endtask

    // One random string of one to eight characters. Most characters are well
    // formed; some are lone surrogates, broken pairs or plain noise.
    task automatic send_string();
        int               n_chars;
        int               kind;
        logic             fin;
        logic [UnitW-1:0] high;
        n_chars = $urandom_range(8, 1);
        for (int c = 0; c < n_chars; c++) begin
            fin  = (c == n_chars - 1);
            kind = $urandom_range(99);
            high = 16'($urandom_range(16'hDBFF, 16'hD800));
            if (kind < 20) begin
                offer_unit(16'($urandom_range(16'h7F)), fin);
            end else if (kind < 35) begin
                offer_unit(16'($urandom_range(16'h7FF, 16'h80)), fin);
            end else if (kind < 50) begin
                if ($urandom_range(1) == 1) begin
                    offer_unit(16'($urandom_range(16'hD7FF, 16'h800)), fin);
                end else begin
                    offer_unit(16'($urandom_range(16'hFFFF, 16'hE000)), fin);
                end
            end else if (kind < 80) begin
                offer_unit(high, 1'b0);
                offer_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), fin);
            end else if (kind < 85) begin
                offer_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), fin);
            end else if (kind < 90) begin
                // A pair whose follower is anything at all, usually not a low surrogate.
                offer_unit(high, 1'b0);
                offer_unit(16'($urandom_range(16'hFFFF)), fin);
            end else if (kind < 93) begin
                offer_unit(high, fin);
            end else begin
                offer_unit(16'($urandom_range(16'hFFFF)), fin);
            end
        end
    endtask

    // Sender: reset, the directed table, a pause until the block has drained,
    // then random strings, and finally the verdict.
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_code_unit <= '0;
        i_last_unit <= 1'b0;
        pair_open    = 1'b0;
        high_bits    = '0;

        directed_rows = '{
            '{16'h0000, 1'b0, 1'b1, 3'd1, 32'h00000000},  // Smallest unit, straight after reset.
            '{16'h007F, 1'b0, 1'b1, 3'd1, 32'h7F000000},
            '{16'h0080, 1'b0, 1'b1, 3'd2, 32'hC2800000},
            '{16'h07FF, 1'b0, 1'b1, 3'd2, 32'hDFBF0000},
            '{16'h0800, 1'b0, 1'b1, 3'd3, 32'hE0A08000},
            '{16'hFFFF, 1'b0, 1'b1, 3'd3, 32'hEFBFBF00},
            '{16'hD7FF, 1'b0, 1'b1, 3'd3, 32'hED9FBF00},  // Just below the surrogates.
            '{16'hE000, 1'b0, 1'b1, 3'd3, 32'hEE808000},  // Just above them.
            '{16'hD800, 1'b0, 1'b1, 3'd0, 32'h00000000},  // Lowest pair.
            '{16'hDC00, 1'b0, 1'b1, 3'd4, 32'hF0908080},
            '{16'hDBFF, 1'b0, 1'b1, 3'd0, 32'h00000000},  // Highest pair.
            '{16'hDFFF, 1'b0, 1'b1, 3'd4, 32'hF48FBFBF},
            '{16'hDC00, 1'b0, 1'b1, 3'd3, 32'hEDB08000},  // Lone low surrogates.
            '{16'hDFFF, 1'b1, 1'b1, 3'd3, 32'hEDBFBF00},
            '{16'hD800, 1'b0, 1'b1, 3'd0, 32'h00000000},  // Follower that is plain text.
            '{16'h0041, 1'b0, 1'b1, 3'd4, 32'hF0908080},
            '{16'hDBFF, 1'b0, 1'b1, 3'd0, 32'h00000000},  // Follower that is another high.
            '{16'hD800, 1'b0, 1'b1, 3'd4, 32'hF48FB080},
            '{16'hD83D, 1'b1, 1'b1, 3'd0, 32'h00000000},  // High surrogate closing a string.
            '{16'h0041, 1'b1, 1'b1, 3'd1, 32'h41000000},
            '{16'h00E9, 1'b0, 1'b0, 3'd0, 32'h00000000},
            '{16'hD83D, 1'b0, 1'b0, 3'd0, 32'h00000000},  // Pair whose follower ends the string.
            '{16'hDE00, 1'b1, 1'b0, 3'd0, 32'h00000000},
            '{16'h20AC, 1'b1, 1'b0, 3'd0, 32'h00000000}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NumDirected; r++) begin
            offer_unit(directed_rows[r].unit, directed_rows[r].fin, directed_rows[r].hand_typed,
                       directed_rows[r].count, directed_rows[r].lead_first);
        end

        // Hold the input back until every owed byte has come out.
        i_valid <= 1'b0;
        while (due_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);

        while (units_sent < NumDirected + NumRandom) begin
            send_string();
        end

        i_valid <= 1'b0;
        while (due_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        // Keep clocking after the drain so that any stray byte is caught.
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: checks each byte taken against the oldest one owed, and drives
    // the stall. Once, it holds off for a long stretch so that the block fills
    // up; for another stretch it never stalls.
    initial begin
        t_utf8_byte want;
        int         hold_left;
        bit         held_once;
        hold_left = 0;
        held_once = 0;
        i_stall  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                bytes_taken++;
                if (due_bytes.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %02h run_last %0b string_end %0b",
                             $time, o_out_byte, o_run_last, o_string_end);
                    fail_count++;
                end else begin
                    want = due_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte: expected %02h, actual %02h",
                                 $time, want.data, o_out_byte);
                        fail_count++;
                    end
                    if (o_run_last !== want.unit_end) begin
                        $display("%0t: run_last: expected %0b, actual %0b",
                                 $time, want.unit_end, o_run_last);
                        fail_count++;
                    end
                    if (o_string_end !== want.text_end) begin
                        $display("%0t: string_end: expected %0b, actual %0b",
                                 $time, want.text_end, o_string_end);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held_once && bytes_taken >= 150) begin
                held_once = 1;
                hold_left = 80;
                i_stall  <= 1'b1;
            end else if (bytes_taken >= 250 && bytes_taken < 330) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 25);
            end
        end
    end

    // Guard against a hung block.
    initial begin
        #200000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/utu8_pkg.sv
rtl/utu8_encode.sv
rtl/utu8_out.sv
rtl/utu8_to_dummy_guard.sv
rtl/utf16_to_utf8_transcoder.sv
test/utf16_to_utf8_transcoder_test.sv
